FILE: rtl/core/ldbc_pkg.sv
package ldbc_pkg;

    localparam int LED_COUNT = 8;
    localparam int PORT_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] DIM_WRAP_RESET  = 8'hFF;
    localparam logic [7:0] PORT_KEEP_RESET = 8'h00;

    typedef logic [LED_COUNT-1:0] t_led_vec;

    typedef enum logic [2:0] {
        KIND_DIM_TICK   = 3'd0,
        KIND_BLINK_TICK = 3'd1,
        KIND_SET_LEVEL  = 3'd2,
        KIND_SET_HIGH   = 3'd3,
        KIND_SET_PERIOD = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_WRAP  = 2'd0,
        CFG_PORT_KEEP = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] led_index;
        logic [7:0] set_value;
        logic [7:0] latch_value;
    } t_item;

endpackage

FILE: rtl/core/ldbc_blink.sv
module ldbc_blink (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  ldbc_pkg::t_item   i_item,
    output ldbc_pkg::t_led_vec o_blink_bits
);
    import ldbc_pkg::*;

    logic [7:0] r_high   [LED_COUNT];
    logic [7:0] r_period [LED_COUNT];
    logic [7:0] r_count  [LED_COUNT];
    t_led_vec   r_bits;

    logic [7:0] n_count [LED_COUNT];
    t_led_vec   n_bits;
    logic [7:0] inc;

    always_comb begin
        n_bits = r_bits;
        for (int i = 0; i < LED_COUNT; i++) begin
            inc        = r_count[i] + 8'd1;
            n_count[i] = inc;
            if (inc > r_period[i]) begin
                n_count[i] = 8'd0;
                n_bits[i]  = 1'b1;
            end
            if (n_count[i] == r_high[i]) begin
                n_bits[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            for (int i = 0; i < LED_COUNT; i++) begin
                r_high[i]   <= 8'd0;
                r_period[i] <= 8'd0;
                r_count[i]  <= 8'd0;
            end
        end else if (i_en) begin
            case (i_item.kind)
                KIND_BLINK_TICK: begin
                    r_bits <= n_bits;
                    for (int i = 0; i < LED_COUNT; i++) begin
                        r_count[i] <= n_count[i];
                    end
                end
                KIND_SET_HIGH: begin
                    for (int i = 0; i < LED_COUNT; i++) begin
                        if (32'(i_item.led_index) == i) begin
                            r_high[i] <= i_item.set_value;
                        end
                    end
                end
                KIND_SET_PERIOD: begin
                    for (int i = 0; i < LED_COUNT; i++) begin
                        if (32'(i_item.led_index) == i) begin
                            r_period[i] <= i_item.set_value;
                            r_count[i]  <= i_item.set_value;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_blink_bits = r_bits;

endmodule

FILE: rtl/core/ldbc_dim.sv
module ldbc_dim (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  ldbc_pkg::t_item    i_item,
    input  logic [7:0]         i_wrap_mask,
    input  ldbc_pkg::t_led_vec i_blink_bits,
    output logic               o_act_phase,
    output ldbc_pkg::t_led_vec o_combined
);
    import ldbc_pkg::*;

    logic [7:0] r_level [LED_COUNT];
    logic [7:0] r_count;
    logic       r_act;
    t_led_vec   r_dim_bits;
    t_led_vec   r_combined;

    logic [7:0] n_count;
    t_led_vec   n_dim_bits;

    always_comb begin
        n_count    = r_count + 8'd1;
        n_dim_bits = r_dim_bits;
        if ((n_count & i_wrap_mask) == 8'd0) begin
            n_dim_bits = '1;
            n_count    = 8'd0;
        end
        for (int i = 0; i < LED_COUNT; i++) begin
            if (n_count == r_level[i]) begin
                n_dim_bits[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= 8'd0;
            r_act      <= 1'b0;
            r_dim_bits <= '0;
            r_combined <= '0;
            for (int i = 0; i < LED_COUNT; i++) begin
                r_level[i] <= 8'd0;
            end
        end else if (i_en) begin
            case (i_item.kind)
                KIND_DIM_TICK: begin
                    r_act <= ~r_act;
                    if (!r_act) begin
                        r_count    <= n_count;
                        r_dim_bits <= n_dim_bits;
                        r_combined <= n_dim_bits & i_blink_bits;
                    end
                end
                KIND_SET_LEVEL: begin
                    for (int i = 0; i < LED_COUNT; i++) begin
                        if (32'(i_item.led_index) == i) begin
                            r_level[i] <= i_item.set_value;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_act_phase = r_act;
    assign o_combined  = r_combined;

endmodule

FILE: rtl/core/led_dim_blink_controller_top.sv
// An accepted input word passes through the input register and then the result register.
// Throughput: 1 word per cycle; input register feeds one pass of per-LED
// compare logic into the result register, stalling only when the result is held.
// Reset (synchronous, active low) clears all LED state and counters, starts in
// the compute phase, and loads dim_wrap_mask = 0xFF, port_keep_mask = 0x00.
module led_dim_blink_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [2:0]                     i_kind,
    input  logic [2:0]                     i_led_index,
    input  logic [7:0]                     i_set_value,
    input  logic [7:0]                     i_latch_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_port_write,
    output logic [7:0]                     o_port_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ldbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);
    import ldbc_pkg::*;

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    logic       r_port_write;
    logic [7:0] r_port_value;
    logic [7:0] r_wrap_mask;
    logic [7:0] r_keep_mask;

    logic       advance;
    logic       act_phase;
    t_led_vec   combined;
    t_led_vec   blink_bits;
    logic [PORT_W+LED_COUNT-1:0] port_ext;
    logic       n_port_write;
    logic [7:0] n_port_value;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= '{kind: i_kind, led_index: i_led_index,
                      set_value: i_set_value, latch_value: i_latch_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_mask <= DIM_WRAP_RESET;
            r_keep_mask <= PORT_KEEP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIM_WRAP:  r_wrap_mask <= i_cfg_data;
                CFG_PORT_KEEP: r_keep_mask <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ldbc_dim u_dim (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_item       (r_in),
        .i_wrap_mask  (r_wrap_mask),
        .i_blink_bits (blink_bits),
        .o_act_phase  (act_phase),
        .o_combined   (combined)
    );

    ldbc_blink u_blink (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_item       (r_in),
        .o_blink_bits (blink_bits)
    );

    always_comb begin
        port_ext     = {{PORT_W{1'b0}}, combined};
        n_port_write = 1'b0;
        n_port_value = 8'd0;
        if (r_in.kind == KIND_DIM_TICK && act_phase) begin
            n_port_write = 1'b1;
            n_port_value = port_ext[PORT_W-1:0] | (r_in.latch_value & r_keep_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_port_write <= n_port_write;
            r_port_value <= n_port_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_port_write = r_port_write;
    assign o_port_value = r_port_value;

endmodule

FILE: tb/tb.sv
module tb;
    import ldbc_pkg::*;

    localparam int LIMIT      = 500000;
    localparam int REPORT_MAX = 10;
    localparam int PHASES     = 10;
    localparam int PHASE_WORDS = 210;

    localparam logic [2:0]           KIND_LAST    = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic       write;
        logic [7:0] value;
    } t_port_word;

    class led_port_board;
        logic [7:0] wrap_mask;
        logic [7:0] keep_mask;
        logic [7:0] dim_count;
        logic       act_phase;
        t_led_vec   dim_bits;
        t_led_vec   blink_bits;
        t_led_vec   lit_bits;
        logic [7:0] levels  [LED_COUNT];
        logic [7:0] highs   [LED_COUNT];
        logic [7:0] periods [LED_COUNT];
        logic [7:0] counts  [LED_COUNT];
        t_port_word words_due[$];
        int         failures;
        int         reports;

        function new();
            wrap_mask  = DIM_WRAP_RESET;
            keep_mask  = PORT_KEEP_RESET;
            dim_count  = '0;
            act_phase  = 1'b0;
            dim_bits   = '0;
            blink_bits = '0;
            lit_bits   = '0;
            foreach (levels[i]) begin
                levels[i]  = '0;
                highs[i]   = '0;
                periods[i] = '0;
                counts[i]  = '0;
            end
            failures = 0;
            reports  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                CFG_DIM_WRAP:  wrap_mask = data;
                CFG_PORT_KEEP: keep_mask = data;
                default: ;
            endcase
        endfunction

        function void take_item(logic [2:0] kind, logic [2:0] idx, logic [7:0] val,
                                logic [7:0] latch);
            t_port_word want;
            want = '0;
            case (kind)
                KIND_DIM_TICK: begin
                    if (!act_phase) begin
                        dim_count = dim_count + 8'd1;
                        if ((dim_count & wrap_mask) == 8'd0) begin
                            dim_bits  = '1;
                            dim_count = '0;
                        end
                        for (int i = 0; i < LED_COUNT; i++)
                            if (dim_count == levels[i])
                                dim_bits[i] = 1'b0;
                        lit_bits = dim_bits & blink_bits;
                    end else begin
                        want.write = 1'b1;
                        want.value = lit_bits[7:0] | (latch & keep_mask);
                    end
                    act_phase = ~act_phase;
                end
                KIND_BLINK_TICK: begin
                    for (int i = 0; i < LED_COUNT; i++) begin
                        counts[i] = counts[i] + 8'd1;
                        if (counts[i] > periods[i]) begin
                            counts[i]     = '0;
                            blink_bits[i] = 1'b1;
                        end
                        if (counts[i] == highs[i])
                            blink_bits[i] = 1'b0;
                    end
                end
                KIND_SET_LEVEL:  levels[idx] = val;
                KIND_SET_HIGH:   highs[idx]  = val;
                KIND_SET_PERIOD: begin
                    periods[idx] = val;
                    counts[idx]  = val;
                end
                default: ;
            endcase
            words_due.push_back(want);
        endfunction

        function void check_word(logic w, logic [7:0] v);
            t_port_word want;
            if (words_due.size() == 0) begin
                failures++;
                if (reports < REPORT_MAX)
                    $display("tb: unexpected word write=%0b value=%02h", w, v);
                reports++;
                return;
            end
            want = words_due.pop_front();
            if (w !== want.write || v !== want.value) begin
                failures++;
                if (reports < REPORT_MAX)
                    $display({"tb: word mismatch: expected write=%0b value=%02h,",
                              " got write=%0b value=%02h"},
                             want.write, want.value, w, v);
                reports++;
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [2:0]           i_kind = '0;
    logic [2:0]           i_led_index = '0;
    logic [7:0]           i_set_value = '0;
    logic [7:0]           i_latch_value = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_port_write;
    logic [7:0]           o_port_value;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;

    led_port_board board;
    bit            src_calm = 1'b0;
    bit            snk_calm = 1'b0;
    int            cycles = 0;

    led_dim_blink_controller_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_led_index   (i_led_index),
        .i_set_value   (i_set_value),
        .i_latch_value (i_latch_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_port_write  (o_port_write),
        .o_port_value  (o_port_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // all tasks start and end at a falling edge
    task automatic push_item(logic [2:0] kind, logic [2:0] idx, logic [7:0] val,
                             logic [7:0] latch);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind        = kind;
        i_led_index   = idx;
        i_set_value   = val;
        i_latch_value = latch;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        board.take_item(kind, idx, val, latch);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random(int n);
        int         r;
        logic [2:0] kind;
        logic [7:0] val;
        for (int k = 0; k < n; k++) begin
            r   = $urandom_range(0, 99);
            val = 8'($urandom_range(0, 255));
            if (r < 45) begin
                kind = KIND_DIM_TICK;
            end else if (r < 72) begin
                kind = KIND_BLINK_TICK;
            end else if (r < 95) begin
                kind = 3'($urandom_range(KIND_SET_LEVEL, KIND_SET_PERIOD));
                if ($urandom_range(0, 3) != 0)
                    val = 8'($urandom_range(0, 15));
            end else begin
                kind = 3'($urandom_range(KIND_SET_PERIOD + 1, KIND_LAST));
            end
            push_item(kind, 3'($urandom_range(0, 7)), val, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_directed();
        push_item(KIND_SET_LEVEL,  3'd0, 8'h00, 8'h00);
        push_item(KIND_SET_LEVEL,  3'd7, 8'hFF, 8'hFF);
        push_item(KIND_SET_LEVEL,  3'd3, 8'h02, 8'h00);
        push_item(KIND_SET_PERIOD, 3'd1, 8'h00, 8'h00);
        // high duration above the period
        push_item(KIND_SET_HIGH,   3'd2, 8'hC8, 8'h00);
        push_item(KIND_SET_PERIOD, 3'd2, 8'h03, 8'h00);
        // count at 255 wraps to 0 on the next tick
        push_item(KIND_SET_PERIOD, 3'd7, 8'hFF, 8'h00);
        push_item(KIND_SET_HIGH,   3'd7, 8'h00, 8'h00);
        push_item(KIND_BLINK_TICK, 3'd0, 8'h00, 8'h00);
        push_item(KIND_BLINK_TICK, 3'd7, 8'hFF, 8'hFF);
        push_item(KIND_DIM_TICK,   3'd0, 8'h00, 8'h00);
        push_item(KIND_DIM_TICK,   3'd0, 8'h00, 8'hFF);
        push_item(KIND_DIM_TICK,   3'd7, 8'hFF, 8'hFF);
        push_item(KIND_DIM_TICK,   3'd0, 8'h00, 8'h00);
        for (int k = KIND_SET_PERIOD + 1; k <= KIND_LAST; k++)
            push_item(k[2:0], 3'd7, 8'hFF, 8'hFF);
        push_item(KIND_SET_HIGH,   3'd4, 8'hFF, 8'h00);
        push_item(KIND_SET_PERIOD, 3'd4, 8'hFF, 8'h00);
        push_item(KIND_DIM_TICK,   3'd0, 8'h00, 8'h00);
        push_item(KIND_DIM_TICK,   3'd0, 8'h00, 8'hAA);
        push_item(KIND_BLINK_TICK, 3'd0, 8'h00, 8'h00);
        push_item(KIND_DIM_TICK,   3'd0, 8'h00, 8'h00);
        push_item(KIND_DIM_TICK,   3'd0, 8'h00, 8'h55);
    endtask

    initial begin
        logic [7:0] wraps [PHASES] = '{8'h03, 8'h00, 8'hFF, 8'h0F, 8'h07,
                                       8'h1F, 8'h00, 8'h03, 8'h00, 8'hFF};
        logic [7:0] keeps [PHASES] = '{8'hF0, 8'hFF, 8'h00, 8'h5A, 8'hA5,
                                       8'hC3, 8'h00, 8'h0F, 8'h00, 8'hFF};
        board = new();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph == 6 || ph == 8) begin
                wraps[ph] = 8'($urandom_range(0, 255));
                keeps[ph] = 8'($urandom_range(0, 255));
            end
            write_reg(CFG_DIM_WRAP, wraps[ph]);
            write_reg(CFG_PORT_KEEP, keeps[ph]);
            if (ph == 4)
                write_reg(CFG_IDX_W'($urandom_range(CFG_PORT_KEEP + 1, CFG_UNMAPPED)),
                          8'($urandom_range(0, 255)));
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);
            if (ph == 0)
                run_directed();
            else
                run_random(PHASE_WORDS);
        end
        drain();
        repeat (10) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = snk_calm ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            board.check_word(o_port_write, o_port_value);
            @(negedge i_clk);
        end
    end
endmodule
